@@ design/eecs_pkg.sv @@
// eecs_pkg: shared types, codes and constants for the spi eeprom command sequencer
// no dependencies; imported by eecs_step, eecs_result_q and the top level
package eecs_pkg;

  // default transfer geometry
  localparam int unsigned BLOCK_BYTES_DEF = 128;
  localparam int unsigned PAGE_BYTES_DEF  = 32;
  localparam int unsigned WORD_BYTES      = 4;

  // result queue geometry
  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;
  localparam int unsigned READY_LEVEL = 2;

  // eeprom opcodes and filler byte
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] DUMMY     = 8'hFF;

  typedef enum logic [2:0] {
    OP_RD_WORD   = 3'd0,
    OP_WR_WORD   = 3'd1,
    OP_RD_BLOCK  = 3'd2,
    OP_WR_BLOCK  = 3'd3,
    OP_RX_BYTE   = 3'd4,
    OP_DATA_BYTE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    REQ_RD_WORD  = 2'd0,
    REQ_WR_WORD  = 2'd1,
    REQ_RD_BLOCK = 2'd2,
    REQ_WR_BLOCK = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_FRAME    = 3'd0,
    KIND_DATA_REQ = 3'd1,
    KIND_RD_BYTE  = 3'd2,
    KIND_RD_WORD  = 3'd3,
    KIND_DONE     = 3'd4
  } kind_e;

  typedef enum logic [9:0] {
    PH_IDLE       = 10'b00_0000_0001,
    PH_WREN       = 10'b00_0000_0010,
    PH_CMD        = 10'b00_0000_0100,
    PH_ADDR_HI    = 10'b00_0000_1000,
    PH_ADDR_LO    = 10'b00_0001_0000,
    PH_RD_DATA    = 10'b00_0010_0000,
    PH_WR_DATA    = 10'b00_0100_0000,
    PH_WAIT_BYTE  = 10'b00_1000_0000,
    PH_STAT_CMD   = 10'b01_0000_0000,
    PH_STAT_DUMMY = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx;
    logic        rel;
    logic [31:0] data;
    logic        last;
  } res_t;

  // up to two results from one request, written to the queue together
  typedef struct packed {
    logic push0;
    logic push1;
    res_t res0;
    res_t res1;
  } push_t;

  function automatic res_t frame_res(input logic [7:0] tx, input logic rel);
    res_t r;
    r.kind = KIND_FRAME;
    r.tx   = tx;
    r.rel  = rel;
    r.data = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic res_t info_res(input kind_e kind, input logic [31:0] data,
                                    input logic last);
    res_t r;
    r.kind = kind;
    r.tx   = '0;
    r.rel  = 1'b0;
    r.data = data;
    r.last = last;
    return r;
  endfunction

endpackage

@@ design/eecs_step.sv @@
// eecs_step: transaction state and next-state logic, one registered request per cycle
// depends on eecs_pkg
module eecs_step #(
  parameter int unsigned BLOCK_BYTES = eecs_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned PAGE_BYTES  = eecs_pkg::PAGE_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2:0]      op_i,
  input  logic [15:0]     addr_i,
  input  logic [31:0]     wdata_i,
  input  logic [7:0]      byte_i,
  output eecs_pkg::push_t push_o
);
  import eecs_pkg::*;

  localparam int unsigned MAX_BYTES  = (BLOCK_BYTES > PAGE_BYTES) ? BLOCK_BYTES : PAGE_BYTES;
  localparam int unsigned IDX_W      = $clog2(MAX_BYTES + 1);
  localparam int unsigned PAGE_COUNT = BLOCK_BYTES / PAGE_BYTES;
  localparam int unsigned PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  phase_e            phase_q, phase_d;
  req_e              req_q, req_d;
  logic [IDX_W-1:0]  idx_q, idx_d, idx_inc;
  logic [PG_W-1:0]   pg_q, pg_d;
  logic [PG_W:0]     pg_inc;
  logic [15:0]       addr_q, addr_d;
  logic [31:0]       ws_q, ws_d;
  op_e               op;
  logic [7:0]        wr_byte;

  assign op      = op_e'(op_i);
  assign idx_inc = idx_q + 1'b1;
  assign pg_inc  = {1'b0, pg_q} + 1'b1;

  // next word byte on a word write, most significant first
  always_comb begin
    unique case (idx_inc[1:0])
      2'd1:    wr_byte = ws_q[23:16];
      2'd2:    wr_byte = ws_q[15:8];
      default: wr_byte = ws_q[7:0];
    endcase
  end

  // transaction sequencing
  always_comb begin
    phase_d = phase_q;
    req_d   = req_q;
    idx_d   = idx_q;
    pg_d    = pg_q;
    addr_d  = addr_q;
    ws_d    = ws_q;
    push_o  = '0;
    if (valid_i) begin
      priority if (phase_q == PH_IDLE) begin
        // start of a transaction; other operations ignored while idle
        if (!op_i[2]) begin
          req_d        = req_e'(op_i[1:0]);
          addr_d       = addr_i;
          ws_d         = (op == OP_WR_WORD) ? wdata_i : 32'd0;
          idx_d        = '0;
          pg_d         = '0;
          push_o.push0 = 1'b1;
          if (op == OP_WR_WORD || op == OP_WR_BLOCK) begin
            phase_d     = PH_WREN;
            push_o.res0 = frame_res(CMD_WREN, 1'b1);
          end else begin
            phase_d     = PH_CMD;
            push_o.res0 = frame_res(CMD_READ, 1'b0);
          end
        end
      end else if (op == OP_DATA_BYTE) begin
        // block data byte, only when one was asked for
        if (phase_q == PH_WAIT_BYTE) begin
          phase_d      = PH_WR_DATA;
          push_o.push0 = 1'b1;
          push_o.res0  = frame_res(byte_i, idx_inc >= IDX_W'(PAGE_BYTES));
        end
      end else if (op == OP_RX_BYTE) begin
        unique case (phase_q)
          PH_WREN: begin
            phase_d      = PH_CMD;
            push_o.push0 = 1'b1;
            push_o.res0  = frame_res(CMD_WRITE, 1'b0);
          end
          PH_CMD: begin
            phase_d      = PH_ADDR_HI;
            push_o.push0 = 1'b1;
            push_o.res0  = frame_res(addr_q[15:8], 1'b0);
          end
          PH_ADDR_HI: begin
            phase_d      = PH_ADDR_LO;
            push_o.push0 = 1'b1;
            push_o.res0  = frame_res(addr_q[7:0], 1'b0);
          end
          PH_ADDR_LO: begin
            idx_d        = '0;
            push_o.push0 = 1'b1;
            if (req_q == REQ_WR_BLOCK) begin
              phase_d     = PH_WAIT_BYTE;
              push_o.res0 = info_res(KIND_DATA_REQ, 32'd0, 1'b1);
            end else if (req_q == REQ_WR_WORD) begin
              phase_d     = PH_WR_DATA;
              push_o.res0 = frame_res(ws_q[31:24], 1'b0);
            end else begin
              phase_d     = PH_RD_DATA;
              push_o.res0 = frame_res(DUMMY, 1'b0);
            end
          end
          PH_RD_DATA: begin
            idx_d        = idx_inc;
            push_o.push0 = 1'b1;
            if (req_q == REQ_RD_WORD) begin
              ws_d = {ws_q[23:0], byte_i};
              if (idx_inc >= IDX_W'(WORD_BYTES)) begin
                phase_d      = PH_IDLE;
                push_o.res0  = info_res(KIND_RD_WORD, {ws_q[23:0], byte_i}, 1'b0);
                push_o.push1 = 1'b1;
                push_o.res1  = info_res(KIND_DONE, 32'd0, 1'b1);
              end else begin
                push_o.res0 = frame_res(DUMMY, idx_inc == IDX_W'(WORD_BYTES - 1));
              end
            end else begin
              push_o.res0  = info_res(KIND_RD_BYTE, {24'd0, byte_i}, 1'b0);
              push_o.push1 = 1'b1;
              if (idx_inc >= IDX_W'(BLOCK_BYTES)) begin
                phase_d     = PH_IDLE;
                push_o.res1 = info_res(KIND_DONE, 32'd0, 1'b1);
              end else begin
                push_o.res1 = frame_res(DUMMY, idx_inc == IDX_W'(BLOCK_BYTES - 1));
              end
            end
          end
          PH_WR_DATA: begin
            idx_d        = idx_inc;
            push_o.push0 = 1'b1;
            if (req_q == REQ_WR_WORD) begin
              if (idx_inc >= IDX_W'(WORD_BYTES)) begin
                phase_d     = PH_STAT_CMD;
                push_o.res0 = frame_res(CMD_RDSR, 1'b0);
              end else begin
                push_o.res0 = frame_res(wr_byte, idx_inc == IDX_W'(WORD_BYTES - 1));
              end
            end else if (idx_inc >= IDX_W'(PAGE_BYTES)) begin
              phase_d     = PH_STAT_CMD;
              push_o.res0 = frame_res(CMD_RDSR, 1'b0);
            end else begin
              phase_d     = PH_WAIT_BYTE;
              push_o.res0 = info_res(KIND_DATA_REQ, 32'd0, 1'b1);
            end
          end
          PH_STAT_CMD: begin
            phase_d      = PH_STAT_DUMMY;
            push_o.push0 = 1'b1;
            push_o.res0  = frame_res(DUMMY, 1'b1);
          end
          PH_STAT_DUMMY: begin
            push_o.push0 = 1'b1;
            if (byte_i[0]) begin
              // write still in progress, poll again
              phase_d     = PH_STAT_CMD;
              push_o.res0 = frame_res(CMD_RDSR, 1'b0);
            end else if (req_q == REQ_WR_BLOCK && pg_inc < (PG_W + 1)'(PAGE_COUNT)) begin
              pg_d        = pg_inc[PG_W-1:0];
              addr_d      = addr_q + 16'(PAGE_BYTES);
              idx_d       = '0;
              phase_d     = PH_WREN;
              push_o.res0 = frame_res(CMD_WREN, 1'b1);
            end else begin
              phase_d     = PH_IDLE;
              push_o.res0 = info_res(KIND_DONE, 32'd0, 1'b1);
            end
          end
          default: begin
            // waiting for a data byte: received bytes are ignored
          end
        endcase
      end else begin
        // unused operation codes are ignored
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      req_q   <= REQ_RD_WORD;
      idx_q   <= '0;
      pg_q    <= '0;
      addr_q  <= '0;
      ws_q    <= '0;
    end else begin
      phase_q <= phase_d;
      req_q   <= req_d;
      idx_q   <= idx_d;
      pg_q    <= pg_d;
      addr_q  <= addr_d;
      ws_q    <= ws_d;
    end
  end

endmodule

@@ design/eecs_result_q.sv @@
// eecs_result_q: small result queue, takes up to two results a cycle, gives one
// depends on eecs_pkg
module eecs_result_q (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  eecs_pkg::push_t             push_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output eecs_pkg::res_t              head_o,
  output logic [eecs_pkg::QCNT_W-1:0] level_o
);
  import eecs_pkg::*;

  res_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = entries_q[rd_ptr_q];
  assign level_o     = cnt_q;
  assign wr_ptr_nx   = wr_ptr_q + 1'b1;

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.push0) + QPTR_W'(push_i.push1);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop);
    cnt_d    = cnt_q + QCNT_W'(push_i.push0) + QCNT_W'(push_i.push1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage, second result lands behind the first
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      entries_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      entries_q[wr_ptr_nx] <= push_i.res1;
    end
  end

endmodule

@@ design/spi_eeprom_command_sequencer.sv @@
// spi_eeprom_command_sequencer: request register, sequencing step and result queue
// flow: a request is held in the request register, handled by the sequencing step,
// and its results are written into the result queue, whose head drives out_valid_o
// throughput: one request per cycle while in_ready_o is high; the single result port
// gives one result per cycle while out_ready_i is high, so two results leave in turn
// reset: rst_ni low clears the request valid flag, returns the sequencer to idle and empties the queue
module spi_eeprom_command_sequencer #(
  parameter int unsigned BLOCK_BYTES = eecs_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned PAGE_BYTES  = eecs_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        release_select_o,
  output logic [31:0] read_data_o,
  output logic        last_o
);
  import eecs_pkg::*;

  logic              req_valid_q;
  logic [2:0]        op_q;
  logic [15:0]       addr_q;
  logic [31:0]       wdata_q;
  logic [7:0]        byte_q;
  logic              accept;
  push_t             push;
  res_t              head;
  logic [QCNT_W-1:0] level;

  // room for two more results behind any request still in flight
  assign in_ready_o = (level <= QCNT_W'(READY_LEVEL));
  assign accept     = in_valid_i & in_ready_o;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      byte_q  <= byte_value_i;
    end
  end

  eecs_step #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_valid_q),
    .op_i   (op_q),
    .addr_i (addr_q),
    .wdata_i(wdata_q),
    .byte_i (byte_q),
    .push_o (push)
  );

  eecs_result_q u_result_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .head_o     (head),
    .level_o    (level)
  );

  // result port
  assign kind_o           = head.kind;
  assign tx_byte_o        = head.tx;
  assign release_select_o = head.rel;
  assign read_data_o      = head.data;
  assign last_o           = head.last;

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // a second result only comes with a first
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> push.push0)
    else $error("second result without first");

  // done always closes the results of its request
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_DONE) |-> last_o)
    else $error("done result without last");

  // only frames carry a transmit byte or a select release
  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_FRAME) |-> (tx_byte_o == 8'd0 && !release_select_o))
    else $error("non-frame result with frame fields");

endmodule

@@ verif/eecs_scoreboard.sv @@
// eecs_scoreboard: watches the request and result channels of the sequencer,
// predicts each result from its own copy of the sequencer state and compares them
// depends on eecs_pkg for the phase, request, kind and result types and the opcodes
`timescale 1ns / 100ps

module eecs_scoreboard #(
  parameter int unsigned BLOCK_BYTES = eecs_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned PAGE_BYTES  = eecs_pkg::PAGE_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [2:0]       operation_i,
  input  logic [15:0]      address_i,
  input  logic [31:0]      write_data_i,
  input  logic [7:0]       byte_value_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [2:0]       kind_i,
  input  logic [7:0]       tx_byte_i,
  input  logic             release_select_i,
  input  logic [31:0]      read_data_i,
  input  logic             last_i,
  output eecs_pkg::phase_e phase_o,
  output int               pending_o,
  output int               requests_o,
  output int               results_o,
  output int               failures_o
);
  import eecs_pkg::*;

  localparam int unsigned PAGE_COUNT   = BLOCK_BYTES / PAGE_BYTES;
  localparam int          REPORT_LIMIT = 10;

  // shadow of the sequencer state
  phase_e      cur_phase;
  req_e        active_req;
  int unsigned byte_idx;
  int unsigned page_idx;
  logic [15:0] cur_addr;
  logic [31:0] shift_word;

  // results owed by the block, oldest first
  res_t        due_results[$];
  int          queued;
  int          mismatches;
  int          requests;
  int          results;

  function automatic void push_frame(input logic [7:0] tx, input logic rel);
    res_t r;
    r.kind = KIND_FRAME;
    r.tx   = tx;
    r.rel  = rel;
    r.data = '0;
    r.last = 1'b1;
    due_results.push_back(r);
  endfunction

  function automatic void push_info(input kind_e kind, input logic [31:0] data,
                                    input logic last_res);
    res_t r;
    r.kind = kind;
    r.tx   = '0;
    r.rel  = 1'b0;
    r.data = data;
    r.last = last_res;
    due_results.push_back(r);
  endfunction

  function automatic void begin_status_poll();
    cur_phase = PH_STAT_CMD;
    push_frame(CMD_RDSR, 1'b0);
  endfunction

  function automatic void end_transfer();
    cur_phase = PH_IDLE;
    push_info(KIND_DONE, '0, 1'b1);
  endfunction

  // one accepted request moves the sequencer and queues what it emits
  function automatic void advance_sequencer(input logic [2:0] op, input logic [15:0] addr,
                                            input logic [31:0] wdata, input logic [7:0] b);
    // start of a transfer, anything else is ignored while idle
    if (cur_phase == PH_IDLE) begin
      if (op > OP_WR_BLOCK) return;
      active_req = req_e'(op[1:0]);
      cur_addr   = addr;
      shift_word = (op == OP_WR_WORD) ? wdata : '0;
      byte_idx   = 0;
      page_idx   = 0;
      if (op == OP_WR_WORD || op == OP_WR_BLOCK) begin
        cur_phase = PH_WREN;
        push_frame(CMD_WREN, 1'b1);
      end else begin
        cur_phase = PH_CMD;
        push_frame(CMD_READ, 1'b0);
      end
      return;
    end

    // block data byte only counts when one was asked for
    if (op == OP_DATA_BYTE) begin
      if (cur_phase == PH_WAIT_BYTE) begin
        cur_phase = PH_WR_DATA;
        push_frame(b, byte_idx + 1 >= PAGE_BYTES);
      end
      return;
    end
    if (op != OP_RX_BYTE) return;

    // received byte of the last frame
    case (cur_phase)
      PH_WREN: begin
        cur_phase = PH_CMD;
        push_frame(CMD_WRITE, 1'b0);
      end
      PH_CMD: begin
        cur_phase = PH_ADDR_HI;
        push_frame(cur_addr[15:8], 1'b0);
      end
      PH_ADDR_HI: begin
        cur_phase = PH_ADDR_LO;
        push_frame(cur_addr[7:0], 1'b0);
      end
      PH_ADDR_LO: begin
        byte_idx = 0;
        if (active_req == REQ_WR_BLOCK) begin
          cur_phase = PH_WAIT_BYTE;
          push_info(KIND_DATA_REQ, '0, 1'b1);
        end else if (active_req == REQ_WR_WORD) begin
          cur_phase = PH_WR_DATA;
          push_frame(shift_word[31:24], 1'b0);
        end else begin
          cur_phase = PH_RD_DATA;
          push_frame(DUMMY, 1'b0);
        end
      end
      PH_RD_DATA: begin
        byte_idx++;
        if (active_req == REQ_RD_WORD) begin
          shift_word = {shift_word[23:0], b};
          if (byte_idx >= WORD_BYTES) begin
            push_info(KIND_RD_WORD, shift_word, 1'b0);
            end_transfer();
          end else begin
            push_frame(DUMMY, byte_idx == WORD_BYTES - 1);
          end
        end else begin
          push_info(KIND_RD_BYTE, {24'b0, b}, 1'b0);
          if (byte_idx >= BLOCK_BYTES) end_transfer();
          else push_frame(DUMMY, byte_idx + 1 == BLOCK_BYTES);
        end
      end
      PH_WR_DATA: begin
        byte_idx++;
        if (active_req == REQ_WR_WORD) begin
          if (byte_idx >= WORD_BYTES) begin_status_poll();
          else push_frame(8'(shift_word >> (24 - 8 * byte_idx)), byte_idx == WORD_BYTES - 1);
        end else if (byte_idx >= PAGE_BYTES) begin
          begin_status_poll();
        end else begin
          cur_phase = PH_WAIT_BYTE;
          push_info(KIND_DATA_REQ, '0, 1'b1);
        end
      end
      PH_STAT_CMD: begin
        cur_phase = PH_STAT_DUMMY;
        push_frame(DUMMY, 1'b1);
      end
      PH_STAT_DUMMY: begin
        // bit 0 is the write-in-progress flag
        if (b[0]) begin
          begin_status_poll();
        end else if (active_req == REQ_WR_BLOCK && page_idx + 1 < PAGE_COUNT) begin
          page_idx++;
          cur_addr  = cur_addr + 16'(PAGE_BYTES);
          byte_idx  = 0;
          cur_phase = PH_WREN;
          push_frame(CMD_WREN, 1'b1);
        end else begin
          end_transfer();
        end
      end
      default: ;
    endcase
  endfunction

  // compare the result on the output with the oldest one owed
  function automatic void check_result();
    res_t want;
    results++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: result with nothing due: kind %0d tx %02h rel %0d data %08h last %0d",
                 $realtime, kind_i, tx_byte_i, release_select_i, read_data_i, last_i);
      return;
    end
    want = due_results.pop_front();
    if (kind_i !== want.kind || tx_byte_i !== want.tx || release_select_i !== want.rel ||
        read_data_i !== want.data || last_i !== want.last) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: result %0d mismatch", $realtime, results);
        $display("  expected kind %0d tx %02h rel %0d data %08h last %0d",
                 want.kind, want.tx, want.rel, want.data, want.last);
        $display("  actual   kind %0d tx %02h rel %0d data %08h last %0d",
                 kind_i, tx_byte_i, release_select_i, read_data_i, last_i);
      end
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_phase  = PH_IDLE;
      active_req = REQ_RD_WORD;
      byte_idx   = 0;
      page_idx   = 0;
      cur_addr   = '0;
      shift_word = '0;
      due_results.delete();
      mismatches = 0;
      requests   = 0;
      results    = 0;
      phase_o    <= PH_IDLE;
      pending_o  <= 0;
      requests_o <= 0;
      results_o  <= 0;
      failures_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        queued = due_results.size();
        advance_sequencer(operation_i, address_i, write_data_i, byte_value_i);
        if (due_results.size() > queued) requests++;
      end
      phase_o    <= cur_phase;
      pending_o  <= due_results.size();
      requests_o <= requests;
      results_o  <= results;
      failures_o <= mismatches;
    end
  end

endmodule

@@ verif/tb_spi_eeprom_command_sequencer.sv @@
// tb_spi_eeprom_command_sequencer: clock, reset, request and result stimulus, watchdog
// and verdict; checking is done by eecs_scoreboard instantiated next to the block
// depends on eecs_pkg, eecs_scoreboard and spi_eeprom_command_sequencer
`timescale 1ns / 100ps

module tb_spi_eeprom_command_sequencer;
  import eecs_pkg::*;

  localparam int unsigned BLOCK_BYTES    = BLOCK_BYTES_DEF;
  localparam int unsigned PAGE_BYTES     = PAGE_BYTES_DEF;
  localparam int          CLK_PERIOD     = 20;
  localparam int          RESET_CYCLES   = 10;
  localparam int          ITEM_TARGET    = 450;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;

  // operation codes the block never acts on
  localparam logic [2:0]  OP_RESERVED_LO = 3'd6;
  localparam logic [2:0]  OP_RESERVED_HI = 3'd7;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [2:0]  operation      = '0;
  logic [15:0] address        = '0;
  logic [31:0] write_data     = '0;
  logic [7:0]  byte_value     = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  tx_byte;
  logic        release_select;
  logic [31:0] read_data;
  logic        last_flag;

  phase_e      seq_phase;
  int          pending;
  int          requests_done;
  int          results_seen;
  int          failures;

  int          sender_run     = 0;
  bit          hold_request   = 1'b0;
  int          started[4]     = '{0, 0, 0, 0};

  always #(CLK_PERIOD / 2) clk = ~clk;

  spi_eeprom_command_sequencer #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .address_i       (address),
    .write_data_i    (write_data),
    .byte_value_i    (byte_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .tx_byte_o       (tx_byte),
    .release_select_o(release_select),
    .read_data_o     (read_data),
    .last_o          (last_flag)
  );

  eecs_scoreboard #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) i_scoreboard (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .operation_i     (operation),
    .address_i       (address),
    .write_data_i    (write_data),
    .byte_value_i    (byte_value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .tx_byte_i       (tx_byte),
    .release_select_i(release_select),
    .read_data_i     (read_data),
    .last_i          (last_flag),
    .phase_o         (seq_phase),
    .pending_o       (pending),
    .requests_o      (requests_done),
    .results_o       (results_seen),
    .failures_o      (failures)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one request at the falling edge and hold it until accepted
  task automatic send_request(input logic [2:0] op, input logic [15:0] addr,
                              input logic [31:0] wdata, input logic [7:0] bval);
    int gap;
    gap = 0;
    if (sender_run > 0) sender_run--;
    else if ($urandom_range(0, 99) < 12) sender_run = $urandom_range(10, 60);
    else if ($urandom_range(0, 99) < 40) gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    address    <= addr;
    write_data <= wdata;
    byte_value <= bval;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // a request the block has to ignore in its present phase
  task automatic send_noise();
    logic [2:0] op;
    if (seq_phase == PH_IDLE) begin
      op = 3'($urandom_range(OP_RX_BYTE, OP_RESERVED_HI));
    end else begin
      case ($urandom_range(0, 2))
        0: op = 3'($urandom_range(OP_RD_WORD, OP_WR_BLOCK));
        1: op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        default: op = (seq_phase == PH_WAIT_BYTE) ? OP_RX_BYTE : OP_DATA_BYTE;
      endcase
    end
    send_request(op, 16'($urandom), $urandom, 8'($urandom));
  endtask

  // one whole transfer: start it, then answer every frame and data request;
  // fill below zero gives random bytes, otherwise that byte everywhere but the status busy bit
  task automatic run_transfer(input op_e req_op, input logic [15:0] addr,
                              input logic [31:0] wdata, input int fill, input int noise_pct);
    logic [7:0] bval;
    int         polls;
    int         busy_streak;
    polls       = 0;
    busy_streak = 0;
    started[int'(req_op)]++;
    send_request(req_op, addr, wdata, 8'($urandom));
    while (seq_phase != PH_IDLE) begin
      bval = (fill < 0) ? 8'($urandom) : 8'(fill);
      if ($urandom_range(0, 99) < noise_pct) begin
        send_noise();
      end else if (seq_phase == PH_WAIT_BYTE) begin
        send_request(OP_DATA_BYTE, 16'($urandom), $urandom, bval);
      end else begin
        // status byte: busy a few times at most, then ready
        if (seq_phase == PH_STAT_DUMMY) begin
          if (fill >= 0) bval[0] = (polls == 0);
          else bval[0] = (busy_streak < 3) && ($urandom_range(0, 3) == 0);
          busy_streak = bval[0] ? busy_streak + 1 : 0;
          polls++;
        end
        send_request(OP_RX_BYTE, 16'($urandom), $urandom, bval);
      end
    end
  endtask

  // result side: random stalls, ready stretches, and one long hold on demand
  initial begin : result_sink
    int stall_left;
    int run_left;
    int r;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 15) run_left = $urandom_range(20, 80);
          else if (r < 70) run_left = 1;
          else stall_left = gap_length();
        end
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          run_left--;
        end
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("tb_spi_eeprom_command_sequencer NOT OK");
    $finish;
  end

  // request stimulus and verdict
  initial begin : stimulus
    int          trans_idx;
    int          r;
    op_e         req_op;
    logic [15:0] addr;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ignored codes while idle, extreme word write with one busy poll,
    // word read of all zero bytes at address zero
    send_request(OP_RX_BYTE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_RESERVED_LO, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_RESERVED_HI, 16'h0000, 32'h0000_0000, 8'h00);
    run_transfer(OP_WR_WORD, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 25);
    run_transfer(OP_RD_WORD, 16'h0000, 32'h0000_0000, 8'h00, 0);

    // random transfers; the first four cover every transfer type
    trans_idx = 0;
    while (requests_done < ITEM_TARGET) begin
      // sender pause until the block has drained
      if (trans_idx == 0 || $urandom_range(0, 9) == 0) begin
        if (pending != 0) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      // long result stall while the block read keeps offering requests
      if (trans_idx == 2) hold_request = 1'b1;
      if ($urandom_range(0, 6) == 0) send_noise();
      case (trans_idx)
        0: req_op = OP_RD_WORD;
        1: req_op = OP_WR_BLOCK;
        2: req_op = OP_RD_BLOCK;
        3: req_op = OP_WR_WORD;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 40) req_op = OP_RD_WORD;
          else if (r < 80) req_op = OP_WR_WORD;
          else if (r < 90) req_op = OP_RD_BLOCK;
          else req_op = OP_WR_BLOCK;
        end
      endcase
      addr = 16'($urandom);
      // page address wrap past the top of the address space
      if (req_op == OP_WR_BLOCK && $urandom_range(0, 1) == 1)
        addr = 16'hFFC0 | 16'($urandom_range(0, 31));
      run_transfer(req_op, addr, $urandom, -1, 8);
      trans_idx++;
    end

    // drain and settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run summary: %0d requests took effect, %0d results checked, %0d failures",
             requests_done, results_seen, failures);
    $display("transfers: %0d word reads, %0d word writes, %0d block reads, %0d block writes",
             started[OP_RD_WORD], started[OP_WR_WORD], started[OP_RD_BLOCK],
             started[OP_WR_BLOCK]);
    if (failures == 0) $display("tb_spi_eeprom_command_sequencer OK");
    else $display("tb_spi_eeprom_command_sequencer NOT OK");
    $finish;
  end

endmodule
